// File: src/usbpd_pkg.sv
package usbpd_pkg;

    localparam int MAX_PDOS_DEF = 7;
    localparam logic [3:0] DEBOUNCE_RESET = 4'd10;
    localparam logic [1:0] REV_RESET = 2'd2;

    // Message types
    localparam logic [4:0] MSG_GOODCRC = 5'd1;
    localparam logic [4:0] MSG_REQUEST = 5'd2;
    localparam logic [4:0] MSG_ACCEPT  = 5'd3;
    localparam logic [4:0] MSG_REJECT  = 5'd4;
    localparam logic [4:0] MSG_PS_RDY  = 5'd6;
    localparam logic [4:0] MSG_SRC_CAP = 5'd1;

    // Item operation codes
    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_RX    = 2'd1;
    localparam logic [1:0] OP_TXDON = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_REQ_IDX  = 2'd1;
    localparam logic [1:0] CFG_REQ_VOLT = 2'd2;

    // Engine state codes as reported on the output
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CABLE   = 3'd1;
    localparam logic [2:0] ST_CAPS    = 3'd2;
    localparam logic [2:0] ST_WACCEPT = 3'd3;
    localparam logic [2:0] ST_WREADY  = 3'd4;
    localparam logic [2:0] ST_READY   = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic        cc1_active;
        logic        cc2_active;
        logic [31:0] rx_word;
        logic        rx_first;
        logic        rx_last;
        logic        rx_frame_ok;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [31:0] tx_word;
        logic        tx_last;
        logic [2:0]  engine_state;
        logic        cc_line_select;
        logic        drive_enable;
        logic        power_ready;
        logic        request_error;
    } out_item_t;

    // Status snapshot the front hands to the back part
    typedef struct packed {
        logic [2:0] state;
        logic       sel_cc;
        logic       driving;
        logic       req_err;
    } status_t;

    // Classified command in the queue: up to two words to send
    typedef struct packed {
        logic [1:0]  nwords;
        logic [31:0] word0;
        logic [31:0] word1;
        status_t     status;
    } cmd_t;

endpackage

// File: src/usbpd_front.sv
module usbpd_front #(
    parameter int MAX_PDOS = usbpd_pkg::MAX_PDOS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               item_valid,
    input  usbpd_pkg::in_item_t item,
    output logic               item_take,
    input  logic               q_full,
    output logic               cmd_push,
    output usbpd_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_CABLE   = 6'b000010,
        S_CAPS    = 6'b000100,
        S_WACCEPT = 6'b001000,
        S_WREADY  = 6'b010000,
        S_READY   = 6'b100000
    } fsm_t;

    fsm_t        state_reg, state_next;
    logic [3:0]  limit_reg;
    logic [2:0]  ridx_reg;
    logic [7:0]  rvolt_reg;
    logic [3:0]  dcount_reg, dcount_next;
    logic [1:0]  lastcc_reg, lastcc_next;
    logic [1:0]  rev_reg, rev_next;
    logic [2:0]  pcount_reg, pcount_next;
    logic [2:0]  txid_reg, txid_next;
    logic        rdone_reg, rdone_next;
    logic        selcc_reg, selcc_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [2:0]  wpos_reg, wpos_next;
    logic        fvalid_reg, fvalid_next;
    logic        drv_reg, drv_next;
    logic [31:0] pdo_mem [MAX_PDOS];

    // Request build: registered PDO read, from which the RDO is formed
    logic        rq_pend_reg;
    logic [31:0] rq_pdo_reg;

    logic        pdo_we;
    logic [2:0]  pdo_wa;
    logic [2:0]  state_code;
    logic [1:0]  line;
    logic [3:0]  dcnt_tmp;
    logic        have;
    logic [4:0]  h_type;
    logic [2:0]  h_ndo;
    logic [2:0]  h_id;
    logic        h_ext;
    logic        reply;
    logic        start_req;
    logic [7:0]  vmin;
    logic [7:0]  vmax;
    logic [7:0]  v;
    logic [11:0] v5;
    logic [31:0] rdo;
    logic [9:0]  cur;
    logic [2:0]  maxp;

    assign maxp = 3'(MAX_PDOS);

    always_comb
    begin
        case (state_reg)
            S_IDLE:    state_code = usbpd_pkg::ST_IDLE;
            S_CABLE:   state_code = usbpd_pkg::ST_CABLE;
            S_CAPS:    state_code = usbpd_pkg::ST_CAPS;
            S_WACCEPT: state_code = usbpd_pkg::ST_WACCEPT;
            S_WREADY:  state_code = usbpd_pkg::ST_WREADY;
            S_READY:   state_code = usbpd_pkg::ST_READY;
            default:   state_code = usbpd_pkg::ST_IDLE;
        endcase
    end

    // Stall while a request is being built or the queue is full
    assign item_take = item_valid && !q_full && !rq_pend_reg;

    // Form the RDO from the registered PDO
    always_comb
    begin
        vmin = rq_pdo_reg[15:8];
        vmax = rq_pdo_reg[24:17];
        v = rvolt_reg;
        if (v > vmax) v = vmax;
        if (v < vmin) v = vmin;
        v5 = 12'(({4'd0, v} << 2) + {4'd0, v});
        cur = rq_pdo_reg[9:0];
        rdo = {1'b0, ridx_reg + 3'd1, 4'b0011, 24'd0};
        if (rq_pdo_reg[31:30] == 2'b11 && rq_pdo_reg[29:28] == 2'b00)
            rdo = rdo | {11'd0, v5, 9'd0} | {25'd0, rq_pdo_reg[6:0]};
        else
            rdo = rdo | {22'd0, cur} | {12'd0, cur, 10'd0};
    end

    always_comb
    begin
        state_next  = state_reg;
        dcount_next = dcount_reg;
        lastcc_next = lastcc_reg;
        rev_next    = rev_reg;
        pcount_next = pcount_reg;
        txid_next   = txid_reg;
        rdone_next  = rdone_reg;
        selcc_next  = selcc_reg;
        hdr_next    = hdr_reg;
        wpos_next   = wpos_reg;
        fvalid_next = fvalid_reg;
        drv_next    = drv_reg;
        pdo_we      = 1'b0;
        pdo_wa      = wpos_reg;
        cmd_push    = 1'b0;
        cmd         = '0;
        start_req   = 1'b0;
        line        = 2'd0;
        dcnt_tmp    = dcount_reg;
        have        = 1'b0;
        reply       = 1'b1;
        h_type      = hdr_reg[4:0];
        h_ndo       = hdr_reg[14:12];
        h_id        = hdr_reg[11:9];
        h_ext       = hdr_reg[15];

        if (rq_pend_reg)
        begin
            // Emit the two-word request
            cmd_push = 1'b1;
            cmd.nwords = 2'd2;
            cmd.word0 = {19'd0, 1'b1, txid_reg, 1'b0, rev_reg, 1'b0, usbpd_pkg::MSG_REQUEST};
            cmd.word1 = rdo;
            cmd.status = '{state: state_code, sel_cc: selcc_reg, driving: drv_reg,
                           req_err: 1'b0};
        end
        else if (item_take)
        begin
            case (item.op)
                usbpd_pkg::OP_POLL:
                begin
                    if (state_reg == S_IDLE)
                    begin
                        line = item.cc1_active ? 2'd1 : (item.cc2_active ? 2'd2 : 2'd0);
                        if (line == 2'd0)
                        begin
                            dcount_next = 4'd0;
                            lastcc_next = 2'd0;
                        end
                        else
                        begin
                            if (lastcc_reg != line)
                            begin
                                lastcc_next = line;
                                dcnt_tmp = 4'd0;
                            end
                            else if (dcount_reg != 4'd15)
                                dcnt_tmp = dcount_reg + 4'd1;
                            dcount_next = dcnt_tmp;
                            if (dcnt_tmp > limit_reg)
                            begin
                                selcc_next = (line == 2'd2);
                                dcount_next = 4'd0;
                                state_next = S_CABLE;
                            end
                        end
                    end
                    else if (state_reg == S_CAPS && rdone_reg)
                    begin
                        state_next = S_WACCEPT;
                        if (ridx_reg >= pcount_reg || ridx_reg >= maxp)
                        begin
                            cmd_push = 1'b1;
                            cmd.nwords = 2'd0;
                            cmd.status = '{state: usbpd_pkg::ST_WACCEPT, sel_cc: selcc_reg,
                                           driving: drv_reg, req_err: 1'b1};
                        end
                        else
                        begin
                            start_req = 1'b1;
                            drv_next = 1'b1;
                        end
                    end
                end
                usbpd_pkg::OP_RX:
                begin
                    if (state_reg != S_IDLE)
                    begin
                        if (item.rx_first)
                        begin
                            hdr_next = item.rx_word[15:0];
                            wpos_next = 3'd0;
                            fvalid_next = item.rx_frame_ok;
                            have = item.rx_frame_ok;
                        end
                        else if (fvalid_reg)
                        begin
                            have = 1'b1;
                            if (!hdr_reg[15] && h_ndo != 3'd0 && h_type == usbpd_pkg::MSG_SRC_CAP
                                && wpos_reg < maxp && wpos_reg < h_ndo)
                                pdo_we = 1'b1;
                            if (wpos_reg != 3'd7)
                                wpos_next = wpos_reg + 3'd1;
                        end
                        if (have && item.rx_last)
                        begin
                            h_type = hdr_next[4:0];
                            h_ndo  = hdr_next[14:12];
                            h_id   = hdr_next[11:9];
                            h_ext  = hdr_next[15];
                            fvalid_next = 1'b0;
                            if (!h_ext)
                            begin
                                if (h_ndo == 3'd0)
                                begin
                                    if (h_type == usbpd_pkg::MSG_GOODCRC)
                                    begin
                                        if (h_id == txid_reg)
                                            txid_next = txid_reg + 3'd1;
                                        reply = 1'b0;
                                        rdone_next = 1'b1;
                                    end
                                    else if (h_type == usbpd_pkg::MSG_ACCEPT)
                                        state_next = S_WREADY;
                                    else if (h_type == usbpd_pkg::MSG_REJECT)
                                        state_next = S_CAPS;
                                    else if (h_type == usbpd_pkg::MSG_PS_RDY)
                                        state_next = S_READY;
                                end
                                else if (h_type == usbpd_pkg::MSG_SRC_CAP)
                                begin
                                    state_next = S_CAPS;
                                    pcount_next = (h_ndo > maxp) ? maxp : h_ndo;
                                    rev_next = hdr_next[7:6];
                                end
                            end
                            if (reply)
                            begin
                                rdone_next = 1'b0;
                                drv_next = 1'b1;
                            end
                        end
                    end
                end
                usbpd_pkg::OP_TXDON:
                begin
                    drv_next = 1'b0;
                    rdone_next = 1'b1;
                end
                default:
                begin
                    state_next  = S_IDLE;
                    dcount_next = 4'd0;
                    lastcc_next = 2'd0;
                    rev_next    = usbpd_pkg::REV_RESET;
                    pcount_next = 3'd0;
                    txid_next   = 3'd0;
                    rdone_next  = 1'b0;
                    selcc_next  = 1'b0;
                    hdr_next    = 16'd0;
                    wpos_next   = 3'd0;
                    fvalid_next = 1'b0;
                    drv_next    = 1'b0;
                end
            endcase
            // Status or GoodCRC for all non-request items
            if (!start_req && !cmd_push)
            begin
                cmd_push = 1'b1;
                if (item.op == usbpd_pkg::OP_RX && have && item.rx_last && reply)
                begin
                    cmd.nwords = 2'd1;
                    cmd.word0 = {20'd0, h_id, 1'b0, rev_next, 1'b0, usbpd_pkg::MSG_GOODCRC};
                end
                else
                    cmd.nwords = 2'd0;
                cmd.status = '{state: 3'd0, sel_cc: selcc_next, driving: drv_next,
                               req_err: 1'b0};
                case (state_next)
                    S_IDLE:    cmd.status.state = usbpd_pkg::ST_IDLE;
                    S_CABLE:   cmd.status.state = usbpd_pkg::ST_CABLE;
                    S_CAPS:    cmd.status.state = usbpd_pkg::ST_CAPS;
                    S_WACCEPT: cmd.status.state = usbpd_pkg::ST_WACCEPT;
                    S_WREADY:  cmd.status.state = usbpd_pkg::ST_WREADY;
                    S_READY:   cmd.status.state = usbpd_pkg::ST_READY;
                    default:   cmd.status.state = usbpd_pkg::ST_IDLE;
                endcase
            end
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            limit_reg   <= usbpd_pkg::DEBOUNCE_RESET;
            ridx_reg    <= 3'd0;
            rvolt_reg   <= 8'd0;
            dcount_reg  <= 4'd0;
            lastcc_reg  <= 2'd0;
            rev_reg     <= usbpd_pkg::REV_RESET;
            pcount_reg  <= 3'd0;
            txid_reg    <= 3'd0;
            rdone_reg   <= 1'b0;
            selcc_reg   <= 1'b0;
            hdr_reg     <= 16'd0;
            wpos_reg    <= 3'd0;
            fvalid_reg  <= 1'b0;
            drv_reg     <= 1'b0;
            rq_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dcount_reg  <= dcount_next;
            lastcc_reg  <= lastcc_next;
            rev_reg     <= rev_next;
            pcount_reg  <= pcount_next;
            txid_reg    <= txid_next;
            rdone_reg   <= rdone_next;
            selcc_reg   <= selcc_next;
            hdr_reg     <= hdr_next;
            wpos_reg    <= wpos_next;
            fvalid_reg  <= fvalid_next;
            drv_reg     <= drv_next;
            rq_pend_reg <= start_req;
            if (cfg_we)
            begin
                case (cfg_index)
                    usbpd_pkg::CFG_DEBOUNCE: limit_reg <= cfg_data[3:0];
                    usbpd_pkg::CFG_REQ_IDX:  ridx_reg  <= cfg_data[2:0];
                    usbpd_pkg::CFG_REQ_VOLT: rvolt_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // PDO store with registered read
    always_ff @(posedge clk)
    begin
        if (pdo_we)
            pdo_mem[pdo_wa] <= item.rx_word;
        if (start_req)
            rq_pdo_reg <= pdo_mem[ridx_reg];
    end

endmodule

// File: src/usbpd_queue.sv
module usbpd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  usbpd_pkg::cmd_t din,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output usbpd_pkg::cmd_t dout
);

    usbpd_pkg::cmd_t mem_reg [2];
    logic            wp_reg;
    logic            rp_reg;
    logic [1:0]      cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign dout = mem_reg[rp_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end

endmodule

// File: src/usbpd_back.sv
module usbpd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  usbpd_pkg::cmd_t      cmd,
    output logic                 cmd_pop,
    output logic                 out_valid,
    output usbpd_pkg::out_item_t out_item,
    input  logic                 out_stall
);

    logic                 oval_reg;
    usbpd_pkg::out_item_t obuf_reg, obuf_next;
    logic                 sec_reg;
    logic                 load;

    assign out_valid = oval_reg;
    assign out_item = obuf_reg;
    assign load = cmd_valid && (!oval_reg || !out_stall);
    assign cmd_pop = load && (cmd.nwords != 2'd2 || sec_reg);

    // Pick the word for the next transaction
    always_comb
    begin
        obuf_next.tx_valid = (cmd.nwords != 2'd0);
        obuf_next.tx_word = (cmd.nwords == 2'd0) ? 32'd0 : (sec_reg ? cmd.word1 : cmd.word0);
        obuf_next.tx_last = (cmd.nwords != 2'd2) || sec_reg;
        obuf_next.engine_state = cmd.status.state;
        obuf_next.cc_line_select = cmd.status.sel_cc;
        obuf_next.drive_enable = cmd.status.driving;
        obuf_next.power_ready = (cmd.status.state == usbpd_pkg::ST_READY);
        obuf_next.request_error = cmd.status.req_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oval_reg <= 1'b0;
            sec_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                oval_reg <= 1'b1;
                sec_reg  <= (cmd.nwords == 2'd2) && !sec_reg;
            end
            else if (!out_stall)
                oval_reg <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
            obuf_reg <= obuf_next;
    end

endmodule

// File: src/usb_pd_sink_negotiator.sv
// USB PD sink negotiator. Items enter on in_valid/in_stall and are classified by a front
// stage that holds the protocol state and the 7-entry PDO store; results go through a
// two-entry queue to an output stage that emits one transaction per cycle while out_stall
// is low. A poll that sends a Request stalls the input while the RDO is formed from the
// registered PDO store read, and the Request's two words leave as separate transactions.
// A result is registered in the queue and then in the output register. Config writes are
// taken at any time but must only occur while the block is idle.
module usb_pd_sink_negotiator #(
    parameter int MAX_PDOS = usbpd_pkg::MAX_PDOS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  usbpd_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output usbpd_pkg::out_item_t out_data
);

    logic            take;
    logic            q_full;
    logic            push;
    usbpd_pkg::cmd_t cmd_in;
    logic            q_ne;
    logic            pop;
    usbpd_pkg::cmd_t cmd_out;

    assign in_stall = !take;

    usbpd_front #(.MAX_PDOS(MAX_PDOS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .item_valid(in_valid), .item(in_data), .item_take(take),
        .q_full(q_full), .cmd_push(push), .cmd(cmd_in)
    );

    usbpd_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .din(cmd_in), .full(q_full),
        .pop(pop), .not_empty(q_ne), .dout(cmd_out)
    );

    usbpd_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_ne), .cmd(cmd_out), .cmd_pop(pop),
        .out_valid(out_valid), .out_item(out_data), .out_stall(out_stall)
    );

    // A stalled result must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed under stall");

    // Power ready only in ready state
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.power_ready == (out_data.engine_state == usbpd_pkg::ST_READY)))
        else $error("power_ready mismatch");

    // Never push into a full queue unless it pops in the same cycle
    a_q: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full && !pop))
        else $error("queue overflow");

endmodule
